// ----- design/derivation_path_parser_macros.svh -----
// assertion helpers for the derivation path parser checker
`ifndef DERIVATION_PATH_PARSER_MACROS_SVH
`define DERIVATION_PATH_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define DPP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define DPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dpp_pkg.sv -----
// ----------------------------------------------------------------------------
// dpp_pkg
// Types, codes and helpers shared by the derivation path parser modules.
// ----------------------------------------------------------------------------
package dpp_pkg;

  localparam int MaxPathDepthDefault = 255;
  localparam logic [7:0] MaxDepthReset = 8'd10;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [2:0] PH_START      = 3'd0;
  localparam logic [2:0] PH_AFTER_M    = 3'd1;
  localparam logic [2:0] PH_COMP_START = 3'd2;
  localparam logic [2:0] PH_DIGITS     = 3'd3;
  localparam logic [2:0] PH_SUFFIX     = 3'd4;
  localparam logic [2:0] PH_ERROR      = 3'd5;

  typedef struct packed {
    logic [31:0] component_value;
    logic [7:0]  component_index;
    logic        is_status;
    logic        path_ok;
    logic [7:0]  path_depth;
    logic        last_of_run;
  } dpp_result_t;

  typedef struct packed {
    logic        push0;
    logic        push1;
    dpp_result_t r0;
    dpp_result_t r1;
  } dpp_push_t;

  function automatic dpp_result_t make_comp(logic [31:0] value, logic [7:0] index,
                                            logic last);
    dpp_result_t r;
    r.component_value = value;
    r.component_index = index;
    r.is_status       = 1'b0;
    r.path_ok         = 1'b0;
    r.path_depth      = 8'd0;
    r.last_of_run     = last;
    return r;
  endfunction

  function automatic dpp_result_t make_status(logic ok, logic [7:0] depth);
    dpp_result_t r;
    r.component_value = 32'd0;
    r.component_index = 8'd0;
    r.is_status       = 1'b1;
    r.path_ok         = ok;
    r.path_depth      = ok ? depth : 8'd0;
    r.last_of_run     = 1'b1;
    return r;
  endfunction

endpackage

// ----- design/dpp_parser.sv -----
// ----------------------------------------------------------------------------
// dpp_parser
// Parse state and one-character step; emits up to two results per character.
// ----------------------------------------------------------------------------
module dpp_parser #(
  parameter int MAX_PATH_DEPTH = dpp_pkg::MaxPathDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          ch,
  input  logic [7:0]          depth_setting,
  output dpp_pkg::dpp_push_t  push
);

  localparam logic [7:0] DepthCap = 8'(MAX_PATH_DEPTH);

  logic [2:0]  phase, phase_next;
  logic [30:0] acc, acc_next;
  logic        first_zero, first_zero_next;
  logic [7:0]  count, count_next;

  logic        digit;
  logic [3:0]  d;
  logic [7:0]  limit;
  logic        fin_ok;
  logic [31:0] comp_word;
  logic [34:0] nv;

  assign digit     = (ch >= dpp_pkg::CH_0) && (ch <= dpp_pkg::CH_9);
  assign d         = digit ? 4'(ch - dpp_pkg::CH_0) : 4'd0;
  assign limit     = (depth_setting < DepthCap) ? depth_setting : DepthCap;
  assign fin_ok    = count < limit;
  assign comp_word = {phase == dpp_pkg::PH_SUFFIX, acc};
  assign nv        = 35'({acc, 3'b000}) + 35'({acc, 1'b0}) + 35'(d);

  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    first_zero_next = first_zero;
    count_next      = count;
    push            = '0;
    if (ch == dpp_pkg::CH_NUL) begin
      push.push0 = 1'b1;
      case (phase)
        dpp_pkg::PH_AFTER_M: begin
          push.r0 = dpp_pkg::make_status(1'b1, count);
        end
        dpp_pkg::PH_DIGITS, dpp_pkg::PH_SUFFIX: begin
          if (fin_ok) begin
            push.push1 = 1'b1;
            push.r0    = dpp_pkg::make_comp(comp_word, count, 1'b0);
            push.r1    = dpp_pkg::make_status(1'b1, count + 8'd1);
          end else begin
            push.r0 = dpp_pkg::make_status(1'b0, 8'd0);
          end
        end
        default: begin
          push.r0 = dpp_pkg::make_status(1'b0, 8'd0);
        end
      endcase
      phase_next      = dpp_pkg::PH_START;
      acc_next        = '0;
      first_zero_next = 1'b0;
      count_next      = '0;
    end else begin
      case (phase)
        dpp_pkg::PH_START, dpp_pkg::PH_COMP_START: begin
          if (phase == dpp_pkg::PH_START && ch == dpp_pkg::CH_M) begin
            phase_next = dpp_pkg::PH_AFTER_M;
          end else if (digit) begin
            acc_next        = 31'(d);
            first_zero_next = (d == 4'd0);
            phase_next      = dpp_pkg::PH_DIGITS;
          end else begin
            phase_next = dpp_pkg::PH_ERROR;
          end
        end
        dpp_pkg::PH_AFTER_M: begin
          phase_next = (ch == dpp_pkg::CH_SLASH) ? dpp_pkg::PH_COMP_START
                                                 : dpp_pkg::PH_ERROR;
        end
        dpp_pkg::PH_DIGITS, dpp_pkg::PH_SUFFIX: begin
          if (digit && phase == dpp_pkg::PH_DIGITS) begin
            if (first_zero || nv[34:31] != 4'd0) begin
              phase_next = dpp_pkg::PH_ERROR;
            end else begin
              acc_next = nv[30:0];
            end
          end else if ((ch == dpp_pkg::CH_APOS || ch == dpp_pkg::CH_H) &&
                       phase == dpp_pkg::PH_DIGITS) begin
            phase_next = dpp_pkg::PH_SUFFIX;
          end else if (ch == dpp_pkg::CH_SLASH) begin
            if (fin_ok) begin
              push.push0 = 1'b1;
              push.r0    = dpp_pkg::make_comp(comp_word, count, 1'b1);
              count_next = count + 8'd1;
              phase_next = dpp_pkg::PH_COMP_START;
            end else begin
              phase_next = dpp_pkg::PH_ERROR;
            end
          end else begin
            phase_next = dpp_pkg::PH_ERROR;
          end
        end
        default: begin
          phase_next = dpp_pkg::PH_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= dpp_pkg::PH_START;
      acc        <= '0;
      first_zero <= 1'b0;
      count      <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      acc        <= acc_next;
      first_zero <= first_zero_next;
      count      <= count_next;
    end
  end

endmodule

// ----- design/dpp_out_queue.sv -----
// ----------------------------------------------------------------------------
// dpp_out_queue
// Four-entry result queue taking up to two results per cycle, one out.
// ----------------------------------------------------------------------------
module dpp_out_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  dpp_pkg::dpp_push_t    push,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dpp_pkg::dpp_result_t  head_data
);

  dpp_pkg::dpp_result_t entries [4];
  logic [1:0] head, tail;
  logic [2:0] count;
  logic       pop;

  assign out_valid = count != 3'd0;
  assign pop       = out_valid && out_ready;
  assign room      = count <= 3'd2;
  assign head_data = entries[head];

  always_ff @(posedge clk) begin
    if (push.push0) begin
      entries[tail] <= push.r0;
    end
    if (push.push1) begin
      entries[tail + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + 2'(pop);
      tail  <= tail + 2'(push.push0) + 2'(push.push1);
      count <= count - 3'(pop) + 3'(push.push0) + 3'(push.push1);
    end
  end

endmodule

// ----- design/derivation_path_parser.sv -----
// ----------------------------------------------------------------------------
// derivation_path_parser
// Streams a key derivation path one character at a time and returns each
// component word, then an ok/reject status with the depth when ok.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    character
//  output    out_valid / out_ready  component_value, component_index,
//                                   is_status, path_ok, path_depth, last_of_run
//  config    cfg_wr_en              cfg_wr_data (depth limit)
//
//  one character per cycle sustained while the result queue has room; each
//  result goes through the input register, then the parse step into the queue
//  the end character yields the final component and status, or status alone
//  rst is synchronous and clears parse state, queue and the depth limit (to 10)
//  a stalled output holds results in a four-entry queue; input stalls once
//  more than two results are waiting
// ----------------------------------------------------------------------------
module derivation_path_parser #(
  parameter int MAX_PATH_DEPTH = dpp_pkg::MaxPathDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  character,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] component_value,
  output logic [7:0]  component_index,
  output logic        is_status,
  output logic        path_ok,
  output logic [7:0]  path_depth,
  output logic        last_of_run
);

  logic [7:0]           depth_setting;
  logic                 held_valid;
  logic [7:0]           held_char;
  logic                 room;
  logic                 advance;
  dpp_pkg::dpp_push_t   step_push;
  dpp_pkg::dpp_push_t   queue_push;
  dpp_pkg::dpp_result_t head_data;

  assign advance  = held_valid && room;
  assign in_ready = !held_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_setting <= dpp_pkg::MaxDepthReset;
    end else if (cfg_wr_en) begin
      depth_setting <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_char <= character;
    end
  end

  dpp_parser #(
    .MAX_PATH_DEPTH (MAX_PATH_DEPTH)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .ch            (held_char),
    .depth_setting (depth_setting),
    .push          (step_push)
  );

  always_comb begin
    queue_push       = step_push;
    queue_push.push0 = step_push.push0 && advance;
    queue_push.push1 = step_push.push1 && advance;
  end

  dpp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (queue_push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head_data (head_data)
  );

  assign component_value = head_data.component_value;
  assign component_index = head_data.component_index;
  assign is_status       = head_data.is_status;
  assign path_ok         = head_data.path_ok;
  assign path_depth      = head_data.path_depth;
  assign last_of_run     = head_data.last_of_run;

endmodule

// ----- design/dpp_checker.sv -----
// ----------------------------------------------------------------------------
// dpp_checker
// Port-level checks on the result stream of the derivation path parser.
// ----------------------------------------------------------------------------
`include "derivation_path_parser_macros.svh"

module dpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] component_value,
  input logic        is_status,
  input logic        path_ok,
  input logic [7:0]  path_depth,
  input logic        last_of_run
);

  `DPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(component_value) && $stable(is_status), "output transaction changed while stalled")
  `DPP_ASSERT_IMP(a_status_last, out_valid && is_status, last_of_run, "status not last of run")
  `DPP_ASSERT_IMP(a_comp_clean, out_valid && !is_status, !path_ok && path_depth == 8'd0, "component carries status fields")
  `DPP_ASSERT_IMP(a_reject_clean, out_valid && is_status && !path_ok, path_depth == 8'd0 && component_value == 32'd0, "rejected status carries data")

endmodule

bind derivation_path_parser dpp_checker u_dpp_checker (.*);
